// ===== src/scba_pkg.sv =====
// Shared types and constants for the size-class block allocator.
// No dependencies.
package scba_pkg;

   localparam int NUM_REQUESTERS = 4;
   localparam int POOL_PAGES     = 16;
   localparam int PAGE_BYTES     = 65536;
   localparam int NUM_CLASSES    = 128;
   localparam int CACHE_LIMIT    = 64;
   localparam int BATCH          = 32;

   localparam int GRAIN_LG     = 3;
   localparam int MAX_SIZE     = NUM_CLASSES << GRAIN_LG;
   localparam int PAGE_GRAN    = PAGE_BYTES >> GRAIN_LG;
   localparam int PAGE_GRAN_LG = $clog2(PAGE_GRAN);
   localparam int NUM_GRANULES = POOL_PAGES * PAGE_GRAN;
   localparam int NUM_LOCAL    = NUM_REQUESTERS * NUM_CLASSES;

   localparam int ADDR_W  = 20;
   localparam int SIZE_W  = 16;
   localparam int THR_W   = 2;
   localparam int GRAN_W  = $clog2(NUM_GRANULES);
   localparam int LINK_W  = GRAN_W + 1;
   localparam int CLS_W   = $clog2(NUM_CLASSES);
   localparam int LI_W    = $clog2(NUM_LOCAL);
   localparam int CNT_W   = 16;
   localparam int LOC_W   = CNT_W + LINK_W;
   localparam int BATCH_W = $clog2(BATCH + 1);
   localparam int PAGES_W = $clog2(POOL_PAGES + 1);
   localparam int GOFF_W  = $clog2(PAGE_GRAN + 2 * NUM_CLASSES + 1);

   localparam logic [LINK_W-1:0] LINK_END = LINK_W'(1) << GRAN_W;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [1:0] ST_OOM       = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_TAKE_RD,
      S_TAKE_WR,
      S_CARVE,
      S_POP_CHK,
      S_POP_WR,
      S_GIVE_RD,
      S_GIVE_WR,
      S_WB
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        status;
      logic [ADDR_W-1:0] addr;
   } result_type;

endpackage

// ===== src/scba_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module scba_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 18
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/scba_ctrl.sv =====
// Allocator sequencer: head, count and link memories plus list walking.
// Depends on scba_pkg and scba_ram.
module scba_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [scba_pkg::THR_W-1:0]    req_thread,
   input  logic [scba_pkg::SIZE_W-1:0]   req_size_bytes,
   input  logic [scba_pkg::ADDR_W-1:0]   req_block_address,
   input  logic                          slot_free,
   output scba_pkg::result_type          done
);

   scba_pkg::state_type state_ff, state_in;
   logic [scba_pkg::LI_W-1:0]    clr_ff, clr_in;
   logic                         op_ff, op_in;
   logic [scba_pkg::CLS_W-1:0]   cls_ff, cls_in;
   logic [scba_pkg::LI_W-1:0]    li_ff, li_in;
   logic [scba_pkg::GRAN_W-1:0]  gaddr_ff, gaddr_in;
   logic [scba_pkg::LINK_W-1:0]  loc_head_ff, loc_head_in;
   logic [scba_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [scba_pkg::LINK_W-1:0]  cen_head_ff, cen_head_in;
   logic [scba_pkg::BATCH_W-1:0] n_ff, n_in;
   logic [scba_pkg::GOFF_W-1:0]  goff_ff, goff_in;
   logic [scba_pkg::PAGES_W-1:0] pages_ff, pages_in;
   logic [1:0]                   status_ff, status_in;
   logic [scba_pkg::ADDR_W-1:0]  res_ff, res_in;
   logic                         wb_ff, wb_in;

   logic                         loc_we, loc_re, cen_we, cen_re, lnk_we, lnk_re;
   logic [scba_pkg::LI_W-1:0]    loc_wa, loc_ra;
   logic [scba_pkg::LOC_W-1:0]   loc_wd, loc_rd;
   logic [scba_pkg::CLS_W-1:0]   cen_wa, cen_ra;
   logic [scba_pkg::LINK_W-1:0]  cen_wd, cen_rd;
   logic [scba_pkg::GRAN_W-1:0]  lnk_wa, lnk_ra;
   logic [scba_pkg::LINK_W-1:0]  lnk_wd, lnk_rd;

   logic [scba_pkg::SIZE_W-1:0]  size_adj;
   logic [scba_pkg::CLS_W-1:0]   req_cls;
   logic [scba_pkg::LINK_W-1:0]  rd_head;
   logic [scba_pkg::CNT_W-1:0]   rd_cnt;
   logic [scba_pkg::GOFF_W-1:0]  bs_g, goff_next;
   logic [scba_pkg::GRAN_W-1:0]  carve_g;

   scba_ram #(.DEPTH(scba_pkg::NUM_LOCAL), .WIDTH(scba_pkg::LOC_W)) u_local (
      .clock(clock), .wr_en(loc_we), .wr_addr(loc_wa), .wr_data(loc_wd),
      .rd_en(loc_re), .rd_addr(loc_ra), .rd_data(loc_rd)
   );

   scba_ram #(.DEPTH(scba_pkg::NUM_CLASSES), .WIDTH(scba_pkg::LINK_W)) u_central (
      .clock(clock), .wr_en(cen_we), .wr_addr(cen_wa), .wr_data(cen_wd),
      .rd_en(cen_re), .rd_addr(cen_ra), .rd_data(cen_rd)
   );

   scba_ram #(.DEPTH(scba_pkg::NUM_GRANULES), .WIDTH(scba_pkg::LINK_W)) u_link (
      .clock(clock), .wr_en(lnk_we), .wr_addr(lnk_wa), .wr_data(lnk_wd),
      .rd_en(lnk_re), .rd_addr(lnk_ra), .rd_data(lnk_rd)
   );

   assign size_adj  = (req_size_bytes == '0) ? scba_pkg::SIZE_W'(1) : req_size_bytes;
   assign req_cls   = scba_pkg::CLS_W'((size_adj - scba_pkg::SIZE_W'(1)) >> scba_pkg::GRAIN_LG);
   assign rd_head   = loc_rd[scba_pkg::LINK_W-1:0];
   assign rd_cnt    = loc_rd[scba_pkg::LOC_W-1:scba_pkg::LINK_W];
   assign bs_g      = scba_pkg::GOFF_W'(cls_ff) + scba_pkg::GOFF_W'(1);
   assign goff_next = goff_ff + bs_g;
   assign carve_g   = (scba_pkg::GRAN_W'(pages_ff) << scba_pkg::PAGE_GRAN_LG)
                      + scba_pkg::GRAN_W'(goff_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scba_pkg::S_CLEAR;
         clr_ff   <= '0;
         pages_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pages_ff <= pages_in;
      end
      op_ff       <= op_in;
      cls_ff      <= cls_in;
      li_ff       <= li_in;
      gaddr_ff    <= gaddr_in;
      loc_head_ff <= loc_head_in;
      cnt_ff      <= cnt_in;
      cen_head_ff <= cen_head_in;
      n_ff        <= n_in;
      goff_ff     <= goff_in;
      status_ff   <= status_in;
      res_ff      <= res_in;
      wb_ff       <= wb_in;
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      op_in       = op_ff;
      cls_in      = cls_ff;
      li_in       = li_ff;
      gaddr_in    = gaddr_ff;
      loc_head_in = loc_head_ff;
      cnt_in      = cnt_ff;
      cen_head_in = cen_head_ff;
      n_in        = n_ff;
      goff_in     = goff_ff;
      pages_in    = pages_ff;
      status_in   = status_ff;
      res_in      = res_ff;
      wb_in       = wb_ff;
      req_ready   = 1'b0;
      done        = '0;
      loc_we      = 1'b0;
      loc_wa      = li_ff;
      loc_wd      = {cnt_ff, loc_head_ff};
      loc_re      = 1'b0;
      loc_ra      = {req_thread, req_cls};
      cen_we      = 1'b0;
      cen_wa      = cls_ff;
      cen_wd      = cen_head_ff;
      cen_re      = 1'b0;
      cen_ra      = req_cls;
      lnk_we      = 1'b0;
      lnk_wa      = gaddr_ff;
      lnk_wd      = loc_head_ff;
      lnk_re      = 1'b0;
      lnk_ra      = loc_head_ff[scba_pkg::GRAN_W-1:0];
      unique case (state_ff)
         scba_pkg::S_CLEAR: begin
            loc_we = 1'b1;
            loc_wa = clr_ff;
            loc_wd = {scba_pkg::CNT_W'(0), scba_pkg::LINK_END};
            cen_we = 1'b1;
            cen_wa = clr_ff[scba_pkg::CLS_W-1:0];
            cen_wd = scba_pkg::LINK_END;
            clr_in = clr_ff + scba_pkg::LI_W'(1);
            if (clr_ff == scba_pkg::LI_W'(scba_pkg::NUM_LOCAL - 1)) begin
               state_in = scba_pkg::S_IDLE;
            end
         end
         scba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_operation;
               cls_in    = req_cls;
               li_in     = {req_thread, req_cls};
               gaddr_in  = req_block_address[scba_pkg::ADDR_W-1:scba_pkg::GRAIN_LG];
               status_in = scba_pkg::ST_OK;
               res_in    = '0;
               if (req_size_bytes > scba_pkg::SIZE_W'(scba_pkg::MAX_SIZE)) begin
                  status_in = scba_pkg::ST_TOO_LARGE;
                  wb_in     = 1'b0;
                  state_in  = scba_pkg::S_WB;
               end else begin
                  loc_re   = 1'b1;
                  cen_re   = 1'b1;
                  wb_in    = 1'b1;
                  state_in = scba_pkg::S_LOAD;
               end
            end
         end
         scba_pkg::S_LOAD: begin
            loc_head_in = rd_head;
            cnt_in      = rd_cnt;
            cen_head_in = cen_rd;
            n_in        = '0;
            if (op_ff == scba_pkg::OP_FREE) begin
               lnk_we      = 1'b1;
               lnk_wa      = gaddr_ff;
               lnk_wd      = rd_head;
               loc_head_in = {1'b0, gaddr_ff};
               cnt_in      = rd_cnt + scba_pkg::CNT_W'(1);
               if (rd_cnt + scba_pkg::CNT_W'(1) > scba_pkg::CNT_W'(scba_pkg::CACHE_LIMIT)) begin
                  state_in = scba_pkg::S_GIVE_RD;
               end else begin
                  state_in = scba_pkg::S_WB;
               end
            end else if (rd_cnt != '0 && !rd_head[scba_pkg::GRAN_W]) begin
               lnk_re   = 1'b1;
               lnk_ra   = rd_head[scba_pkg::GRAN_W-1:0];
               state_in = scba_pkg::S_POP_WR;
            end else begin
               state_in = scba_pkg::S_TAKE_RD;
            end
         end
         scba_pkg::S_TAKE_RD: begin
            if (!cen_head_ff[scba_pkg::GRAN_W] && n_ff != scba_pkg::BATCH_W'(scba_pkg::BATCH)) begin
               lnk_re   = 1'b1;
               lnk_ra   = cen_head_ff[scba_pkg::GRAN_W-1:0];
               state_in = scba_pkg::S_TAKE_WR;
            end else if (n_ff == '0) begin
               if (pages_ff >= scba_pkg::PAGES_W'(scba_pkg::POOL_PAGES)) begin
                  status_in = scba_pkg::ST_OOM;
                  state_in  = scba_pkg::S_WB;
               end else begin
                  goff_in  = '0;
                  state_in = scba_pkg::S_CARVE;
               end
            end else begin
               state_in = scba_pkg::S_POP_CHK;
            end
         end
         scba_pkg::S_TAKE_WR: begin
            lnk_we      = 1'b1;
            lnk_wa      = cen_head_ff[scba_pkg::GRAN_W-1:0];
            lnk_wd      = loc_head_ff;
            loc_head_in = cen_head_ff;
            cnt_in      = cnt_ff + scba_pkg::CNT_W'(1);
            cen_head_in = lnk_rd;
            n_in        = n_ff + scba_pkg::BATCH_W'(1);
            state_in    = scba_pkg::S_TAKE_RD;
         end
         scba_pkg::S_CARVE: begin
            lnk_we      = 1'b1;
            lnk_wa      = carve_g;
            lnk_wd      = cen_head_ff;
            cen_head_in = {1'b0, carve_g};
            goff_in     = goff_next;
            if (goff_next + bs_g > scba_pkg::GOFF_W'(scba_pkg::PAGE_GRAN)) begin
               pages_in = pages_ff + scba_pkg::PAGES_W'(1);
               n_in     = '0;
               state_in = scba_pkg::S_TAKE_RD;
            end
         end
         scba_pkg::S_POP_CHK: begin
            if (cnt_ff != '0 && !loc_head_ff[scba_pkg::GRAN_W]) begin
               lnk_re   = 1'b1;
               state_in = scba_pkg::S_POP_WR;
            end else begin
               status_in = scba_pkg::ST_OOM;
               state_in  = scba_pkg::S_WB;
            end
         end
         scba_pkg::S_POP_WR: begin
            loc_head_in = lnk_rd;
            cnt_in      = cnt_ff - scba_pkg::CNT_W'(1);
            res_in      = scba_pkg::ADDR_W'({loc_head_ff[scba_pkg::GRAN_W-1:0],
                                             scba_pkg::GRAIN_LG'(0)});
            state_in    = scba_pkg::S_WB;
         end
         scba_pkg::S_GIVE_RD: begin
            if (cnt_ff != '0 && !loc_head_ff[scba_pkg::GRAN_W]
                && n_ff != scba_pkg::BATCH_W'(scba_pkg::BATCH)) begin
               lnk_re   = 1'b1;
               state_in = scba_pkg::S_GIVE_WR;
            end else begin
               state_in = scba_pkg::S_WB;
            end
         end
         scba_pkg::S_GIVE_WR: begin
            lnk_we      = 1'b1;
            lnk_wa      = loc_head_ff[scba_pkg::GRAN_W-1:0];
            lnk_wd      = cen_head_ff;
            cen_head_in = loc_head_ff;
            loc_head_in = lnk_rd;
            cnt_in      = cnt_ff - scba_pkg::CNT_W'(1);
            n_in        = n_ff + scba_pkg::BATCH_W'(1);
            state_in    = scba_pkg::S_GIVE_RD;
         end
         scba_pkg::S_WB: begin
            loc_we = wb_ff;
            cen_we = wb_ff;
            if (slot_free) begin
               done.valid  = 1'b1;
               done.status = status_ff;
               done.addr   = res_ff;
               state_in    = scba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = scba_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/size_class_block_allocator.sv =====
// Top level of the size-class block allocator: sequencer and result register.
// Depends on scba_pkg and scba_ctrl.
//
// Usage: an item on the req_ channel is an allocate or free for one requester
// and byte size; each item gives exactly one item on the rsp_ channel
// (status and, for a good allocate, the block's byte offset).
// req_ready is high only while the sequencer is idle; one item is in work at
// a time. Paths an item can take:
//   too large size            straight to the result
//   free, no spill            block pushed on the local list
//   allocate from local list  block popped from the local list
//   refill                    blocks moved from central first (up to 32)
//   new page                  blocks carved to central (up to 8192)
//   spill                     blocks returned to central (32)
// Every step is bound by the single link memory port pair.
// After reset the head and count memories are cleared, one entry a cycle,
// through every local entry; req_ready stays low during that pass.
// Results wait in an output register; the next item is accepted while it
// waits, and the sequencer holds its finished item until the register frees.
module size_class_block_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic [scba_pkg::THR_W-1:0]  req_thread,
   input  logic [scba_pkg::SIZE_W-1:0] req_size_bytes,
   input  logic [scba_pkg::ADDR_W-1:0] req_block_address,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [scba_pkg::ADDR_W-1:0] rsp_block_address_res
);

   scba_pkg::result_type        done;
   logic                        slot_free;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  status_ff, status_in;
   logic [scba_pkg::ADDR_W-1:0] addr_ff, addr_in;

   scba_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_thread(req_thread),
      .req_size_bytes(req_size_bytes), .req_block_address(req_block_address),
      .slot_free(slot_free), .done(done)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done.valid) begin
         rsp_valid_in = 1'b1;
         status_in    = done.status;
         addr_in      = done.addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      addr_ff   <= addr_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_block_address_res = addr_ff;

   a_done_has_slot: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> slot_free)
      else $error("result issued while output register busy");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("item taken during clearing pass");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      done.valid && done.status != scba_pkg::ST_OK |-> done.addr == '0)
      else $error("failed allocate carries an address");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for size_class_block_allocator: directed table, then
// alloc/free bursts with noise, checked against an in-bench allocator model or typed results.
// Depends on scba_pkg and the allocator RTL.
module tb;

   localparam int unsigned NIL        = 32'h8000_0000;
   localparam int          N_ITEMS    = 450;
   localparam int          CYCLE_CAP  = 3_000_000;

   typedef struct packed {
      logic [1:0]                  status;
      logic [scba_pkg::ADDR_W-1:0] addr;
   } rsp_item_type;

   typedef struct {
      logic                        op;
      logic [scba_pkg::THR_W-1:0]  thr;
      logic [scba_pkg::SIZE_W-1:0] size;
      logic [scba_pkg::ADDR_W-1:0] addr;
      bit                          typed;
      logic [1:0]                  status;
      logic [scba_pkg::ADDR_W-1:0] res;
   } table_row_type;

   typedef struct {
      logic [scba_pkg::SIZE_W-1:0] size;
      logic [scba_pkg::ADDR_W-1:0] addr;
   } block_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_operation = scba_pkg::OP_ALLOC;
   logic [scba_pkg::THR_W-1:0]  req_thread = '0;
   logic [scba_pkg::SIZE_W-1:0] req_size_bytes = '0;
   logic [scba_pkg::ADDR_W-1:0] req_block_address = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [1:0]                  rsp_status;
   logic [scba_pkg::ADDR_W-1:0] rsp_block_address_res;

   // allocator model state
   int unsigned link_mem [scba_pkg::NUM_GRANULES];
   int unsigned central_top [scba_pkg::NUM_CLASSES];
   int unsigned cache_top [scba_pkg::NUM_LOCAL];
   int unsigned cache_cnt [scba_pkg::NUM_LOCAL];
   int unsigned pages_taken;

   rsp_item_type pending_rsp[$];
   int        sent;
   int        idle_pct;
   int        stall_pct;
   int        mismatches;
   int        cycles;
   int        n_alloc_ok, n_oom, n_too_large, n_free, n_spill, n_refill, n_carve;

   size_class_block_allocator i_dut (.*);

   always #6 clock = ~clock;

   function automatic int unsigned refill_cache(int unsigned cls, int unsigned li);
      int unsigned n;
      int unsigned g;
      n = 0;
      while (central_top[cls] < scba_pkg::NUM_GRANULES && n < scba_pkg::BATCH) begin
         g = central_top[cls];
         central_top[cls] = link_mem[g];
         link_mem[g] = cache_top[li];
         cache_top[li] = g;
         cache_cnt[li]++;
         n++;
      end
      if (n > 0) n_refill++;
      return n;
   endfunction

   function automatic rsp_item_type predict_rsp(logic op, logic [scba_pkg::THR_W-1:0] thr,
                                                logic [scba_pkg::SIZE_W-1:0] size_in,
                                                logic [scba_pkg::ADDR_W-1:0] addr);
      rsp_item_type r;
      int unsigned  size, cls, li, g, bs, n;
      r = '0;
      size = (size_in == 0) ? 1 : size_in;
      if (size > scba_pkg::MAX_SIZE) begin
         r.status = scba_pkg::ST_TOO_LARGE;
         n_too_large++;
         return r;
      end
      cls = (size + 7) / 8 - 1;
      li = (thr % scba_pkg::NUM_REQUESTERS) * scba_pkg::NUM_CLASSES + cls;
      if (op == scba_pkg::OP_ALLOC) begin
         if (cache_cnt[li] == 0 || cache_top[li] >= scba_pkg::NUM_GRANULES) begin
            if (refill_cache(cls, li) == 0) begin
               if (pages_taken >= scba_pkg::POOL_PAGES) begin
                  r.status = scba_pkg::ST_OOM;
                  n_oom++;
                  return r;
               end
               bs = (cls + 1) * 8;
               for (int unsigned i = 0; i < scba_pkg::PAGE_BYTES / bs; i++) begin
                  g = (pages_taken * scba_pkg::PAGE_BYTES + i * bs) / 8;
                  link_mem[g] = central_top[cls];
                  central_top[cls] = g;
               end
               pages_taken++;
               n_carve++;
               n = refill_cache(cls, li);
            end
         end
         if (cache_cnt[li] > 0 && cache_top[li] < scba_pkg::NUM_GRANULES) begin
            g = cache_top[li];
            cache_top[li] = link_mem[g];
            cache_cnt[li]--;
            r.addr = scba_pkg::ADDR_W'(g * 8);
            n_alloc_ok++;
         end else begin
            r.status = scba_pkg::ST_OOM;
            n_oom++;
         end
         return r;
      end
      n_free++;
      g = addr / 8;
      if (g >= scba_pkg::NUM_GRANULES) return r;
      link_mem[g] = cache_top[li];
      cache_top[li] = g;
      cache_cnt[li]++;
      if (cache_cnt[li] > scba_pkg::CACHE_LIMIT) begin
         n = 0;
         n_spill++;
         while (cache_cnt[li] > 0 && cache_top[li] < scba_pkg::NUM_GRANULES
                && n < scba_pkg::BATCH) begin
            g = cache_top[li];
            cache_top[li] = link_mem[g];
            cache_cnt[li]--;
            link_mem[g] = central_top[cls];
            central_top[cls] = g;
            n++;
         end
      end
      return r;
   endfunction

   function automatic void set_phase();
      case ((sent * 4) / N_ITEMS)
         0: begin
            idle_pct = 0;
            stall_pct = 0;
         end
         1: begin
            idle_pct = 73;
            stall_pct = 0;
         end
         2: begin
            idle_pct = 0;
            stall_pct = 73;
         end
         default: begin
            idle_pct = 24;
            stall_pct = 24;
         end
      endcase
   endfunction

   task automatic send_item(input logic op, input logic [scba_pkg::THR_W-1:0] thr,
                            input logic [scba_pkg::SIZE_W-1:0] size,
                            input logic [scba_pkg::ADDR_W-1:0] addr,
                            input bit typed, input rsp_item_type typed_rsp,
                            output rsp_item_type got);
      set_phase();
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_thread <= thr;
      req_size_bytes <= size;
      req_block_address <= addr;
      do @(posedge clock); while (!req_ready);
      got = predict_rsp(op, thr, size, addr);
      pending_rsp = {pending_rsp, (typed ? typed_rsp : got)};
      sent++;
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp: status %0d addr %h", rsp_status,
                        rsp_block_address_res);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status || rsp_block_address_res !== want.addr) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp mismatch: exp status %0d addr %h, got status %0d addr %h",
                           want.status, want.addr, rsp_status, rsp_block_address_res);
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb NOT OK");
         $finish;
      end
   end

   table_row_type dir_rows [$];

   function automatic table_row_type row(logic op, logic [scba_pkg::THR_W-1:0] thr,
                                         logic [scba_pkg::SIZE_W-1:0] size,
                                         logic [scba_pkg::ADDR_W-1:0] addr,
                                         bit typed = 0, logic [1:0] st = scba_pkg::ST_OK);
      table_row_type t;
      t.op = op;
      t.thr = thr;
      t.size = size;
      t.addr = addr;
      t.typed = typed;
      t.status = st;
      t.res = '0;
      return t;
   endfunction

   initial begin
      rsp_item_type got, typed_rsp;
      block_type    burst[$];
      block_type    b;
      int           kind, cls, n, k, room;
      logic [scba_pkg::THR_W-1:0] thr;

      sent = 0;
      mismatches = 0;
      idle_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < scba_pkg::NUM_CLASSES; i++) central_top[i] = NIL;
      for (int i = 0; i < scba_pkg::NUM_LOCAL; i++) begin
         cache_top[i] = NIL;
         cache_cnt[i] = 0;
      end
      pages_taken = 0;

      // directed: extremes, too large, unaligned and bogus frees, pool exhaustion
      dir_rows = {dir_rows, row(scba_pkg::OP_ALLOC, 2'd0, 16'd0, 20'hFFFFF)};
      dir_rows = {dir_rows, row(scba_pkg::OP_ALLOC, 2'd1, 16'd1024, '0)};
      dir_rows = {dir_rows, row(scba_pkg::OP_ALLOC, 2'd2, 16'd1025, '0, 1,
                                scba_pkg::ST_TOO_LARGE)};
      dir_rows = {dir_rows, row(scba_pkg::OP_FREE, 2'd3, 16'hFFFF, 20'hFFFFF, 1,
                                scba_pkg::ST_TOO_LARGE)};
      dir_rows = {dir_rows, row(scba_pkg::OP_FREE, 2'd3, 16'd8, 20'hFFFFF, 1,
                                scba_pkg::ST_OK)};
      dir_rows = {dir_rows, row(scba_pkg::OP_ALLOC, 2'd3, 16'd7, '0)};
      dir_rows = {dir_rows, row(scba_pkg::OP_FREE, 2'd2, 16'd1024, 20'h00000, 1,
                                scba_pkg::ST_OK)};
      dir_rows = {dir_rows, row(scba_pkg::OP_ALLOC, 2'd2, 16'd1023, '0)};
      dir_rows = {dir_rows, row(scba_pkg::OP_ALLOC, 2'd2, 16'd1017, '0)};
      for (int c = 1; c <= 14; c++)
         dir_rows = {dir_rows, row(scba_pkg::OP_ALLOC, 2'(c), 16'(c * 8 + 8), '0)};
      dir_rows = {dir_rows, row(scba_pkg::OP_ALLOC, 2'd0, 16'd128, '0, 1,
                                scba_pkg::ST_OOM)};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         typed_rsp.status = dir_rows[i].status;
         typed_rsp.addr = dir_rows[i].res;
         send_item(dir_rows[i].op, dir_rows[i].thr, dir_rows[i].size, dir_rows[i].addr,
                   dir_rows[i].typed, typed_rsp, got);
      end

      // random: alloc bursts freed back in mixed order, plus noise
      typed_rsp = '0;
      while (sent < N_ITEMS) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            send_item(1'($urandom_range(1)), 2'($urandom_range(3)),
                      16'($urandom_range(65535, 1025)), 20'($urandom), 0, typed_rsp, got);
         end else if (kind < 16) begin
            send_item(scba_pkg::OP_FREE, 2'($urandom_range(3)), 16'($urandom_range(1024)),
                      20'($urandom), 0, typed_rsp, got);
         end else if (kind < 22) begin
            send_item(scba_pkg::OP_ALLOC, 2'($urandom_range(3)), 16'($urandom_range(1024)),
                      '0, 0, typed_rsp, got);
         end else begin
            cls = $urandom_range(15);
            if (cls == 15) cls = 127;
            thr = 2'($urandom_range(3));
            n = $urandom_range(80, 1);
            room = (N_ITEMS - sent) / 2;
            if (room < 1) room = 1;
            if (n > room) n = room;
            burst.delete();
            for (int i = 0; i < n; i++) begin
               b.size = (cls == 0) ? 16'($urandom_range(8))
                                   : 16'(cls * 8 + $urandom_range(8, 1));
               send_item(scba_pkg::OP_ALLOC, thr, b.size, '0, 0, typed_rsp, got);
               if (got.status == scba_pkg::ST_OK) begin
                  b.addr = got.addr;
                  burst = {burst, b};
               end
            end
            if ($urandom_range(99) < 40) thr = 2'($urandom_range(3));
            while (burst.size() > 0) begin
               k = $urandom_range(burst.size() - 1);
               b = burst[k];
               burst.delete(k);
               b.size = (cls == 0) ? 16'($urandom_range(8))
                                   : 16'(cls * 8 + $urandom_range(8, 1));
               send_item(scba_pkg::OP_FREE, thr, b.size, b.addr, 0, typed_rsp, got);
            end
         end
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("%0d items: %0d allocs ok, %0d out of memory, %0d too large, %0d frees",
               sent, n_alloc_ok, n_oom, n_too_large, n_free);
      $display("pages carved %0d, refills %0d, spills %0d", n_carve, n_refill, n_spill);
      if (mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
